@@ src/chained_double_sha256_root_top_defines.svh @@
// Assertion macros for the chained double SHA-256 root block.
`ifndef CHAINED_DOUBLE_SHA256_ROOT_TOP_DEFINES_SVH
`define CHAINED_DOUBLE_SHA256_ROOT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CDS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define CDS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CDS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define CDS_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ src/cds_pkg.sv @@
// Package: SHA-256 constants and round helpers for the chained root block.
package cds_pkg;

    localparam int LeafWidth = 64;
    localparam int WordWidth = 32;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [255:0] digest_t;

    function automatic word_t k_const(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    localparam digest_t HashInit = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

    // 256-bit little-endian leaf bytes to eight big-endian message words,
    // word 0 in the top bits.
    function automatic digest_t bytes_to_words(input logic [255:0] b);
        digest_t w;
        for (int i = 0; i < 32; i++) begin
            w[255 - 8*i -: 8] = b[8*i +: 8];
        end
        return w;
    endfunction

endpackage

@@ src/chained_double_sha256_root_top.sv @@
// Top level: chained double SHA-256 over a list of 256-bit leaves.
//
// Input stream s_axis: one beat per leaf; tdata carries the leaf as four
// 64-bit words (byte 0 in bits 7:0), tlast marks the final leaf of a list.
// Output stream m_axis: one beat per list, the 256-bit root, same layout.
// The first leaf of a list is only stored. Every later leaf runs three
// SHA-256 compressions on one round unit: 16-entry schedule window, 64
// rounds plus a load and a final add each. A last leaf then presents the
// root on m_axis; the block holds it and takes no new beat until it is
// accepted, so a stalled receiver stalls the input too. s_axis_tready is
// high only while idle. Reset clears the chain (no list started) and
// drops m_axis_tvalid.
module chained_double_sha256_root_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // leaf_word0, leaf_word1, leaf_word2, leaf_word3
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata   // root_word0, root_word1, root_word2, root_word3
);
    import cds_pkg::*;
    `include "chained_double_sha256_root_top_defines.svh"

    logic [2:0]   state_reg, state_next;
    logic         have_reg, have_next;
    logic         last_reg, last_next;
    logic [255:0] run_reg, run_next;     // running value, byte layout
    logic [255:0] leaf_reg, leaf_next;
    logic [1:0]   pass_reg, pass_next;   // 0,1: first hash blocks, 2: second hash
    logic [5:0]   rnd_reg, rnd_next;
    digest_t      hst_reg, hst_next;     // chaining state H0..H7
    digest_t      wrk_reg, wrk_next;     // a..h
    logic [511:0] sch_reg, sch_next;     // w window, w[t] in top word

    word_t a, b, c, d, e, f, g, h, wt, t1, t2, wn;
    word_t s0w, s1w;
    logic [511:0] blk;
    digest_t      sum;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = wrk_reg;
        wt = sch_reg[511 -: 32];
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + k_const(rnd_reg) + wt;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        s0w = sch_reg[479 -: 32];
        s0w = rotr(s0w, 7) ^ rotr(s0w, 18) ^ (s0w >> 3);
        s1w = sch_reg[63 -: 32];
        s1w = rotr(s1w, 17) ^ rotr(s1w, 19) ^ (s1w >> 10);
        wn = wt + s0w + sch_reg[223 -: 32] + s1w;
        for (int i = 0; i < 8; i++) begin
            sum[32*i +: 32] = hst_reg[32*i +: 32] + wrk_reg[32*i +: 32];
        end
        case (pass_reg)
            2'd0: blk = {bytes_to_words(run_reg), bytes_to_words(leaf_reg)};
            2'd1: blk = {32'h80000000, 448'd0, 32'd512};
            default: blk = {hst_reg, 32'h80000000, 192'd0, 32'd256};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        have_next = have_reg;
        last_next = last_reg;
        run_next = run_reg;
        leaf_next = leaf_reg;
        pass_next = pass_reg;
        rnd_next = rnd_reg;
        hst_next = hst_reg;
        wrk_next = wrk_reg;
        sch_next = sch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                    leaf_next = s_axis_tdata;
                    if (!have_reg)
                    begin
                        run_next = s_axis_tdata;
                        have_next = 1'b1;
                        state_next = s_axis_tlast ? ST_OUT : ST_IDLE;
                    end
                    else
                    begin
                        pass_next = 2'd0;
                        hst_next = HashInit;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                sch_next = blk;
                wrk_next = hst_reg;
                rnd_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                wrk_next = {t1 + t2, a, b, c, d + t1, e, f, g};
                sch_next = {sch_reg[479:0], wn};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (pass_reg == 2'd2)
                begin
                    for (int i = 0; i < 32; i++) begin
                        run_next[8*i +: 8] = sum[255 - 8*i -: 8];
                    end
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end
                else
                begin
                    hst_next = (pass_reg == 2'd1) ? HashInit : sum;
                    state_next = ST_LOAD;
                end
                // second hash block takes the first digest from mid_reg
                if (pass_reg == 2'd1)
                begin
                    hst_next = HashInit;
                end
                pass_next = pass_reg + 2'd1;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    run_next = '0;
                    have_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // pass 1 end: digest must be kept for the second hash block
    digest_t mid_reg, mid_next;
    always_comb
    begin
        mid_next = mid_reg;
        if (state_reg == ST_ADD && pass_reg == 2'd1)
        begin
            mid_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            have_reg <= 1'b0;
            run_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg <= have_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        leaf_reg <= leaf_next;
        pass_reg <= pass_next;
        rnd_reg <= rnd_next;
        hst_reg <= (state_reg == ST_LOAD && pass_reg == 2'd2) ? HashInit : hst_next;
        wrk_reg <= wrk_next;
        mid_reg <= mid_next;
        sch_reg <= (state_reg == ST_LOAD && pass_reg == 2'd2)
            ? {mid_reg, 32'h80000000, 192'd0, 32'd256} : sch_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = run_reg;

    `CDS_ASSERT_IMP(a_out_has_run, clk, rst_n, m_axis_tvalid, have_reg)
    `CDS_ASSERT_IMP(a_excl, clk, rst_n, s_axis_tready, !m_axis_tvalid)
    `CDS_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CDS_ASSERT_NXT(a_done_clear, clk, rst_n, m_axis_tvalid && m_axis_tready,
        !have_reg && s_axis_tready)

endmodule
